>>> design/wsdf_pkg.sv
package wsdf_pkg;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_CLOSE   = 2'd2;

	localparam logic [3:0] OPCODE_CLOSE = 4'h8;
	localparam logic [6:0] LEN_EXT16    = 7'd126;
	localparam logic [6:0] LEN_EXT64    = 7'd127;
	localparam logic [3:0] EXT16_BYTES  = 4'd2;
	localparam logic [3:0] EXT64_BYTES  = 4'd8;
	localparam logic [3:0] KEY_BYTES    = 4'd4;

	localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd8191;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic        last;
		logic [15:0] kept_len;
	} result_t;

endpackage

>>> design/wsdf_parser.sv
module wsdf_parser import wsdf_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    stream_byte,
	input  logic [15:0]   max_payload_bytes,
	output logic          res_valid,
	output result_t       res
);

	typedef enum logic [2:0] {
		PH_HDR0 = 3'd0,
		PH_HDR1 = 3'd1,
		PH_EXT  = 3'd2,
		PH_MASK = 3'd3,
		PH_DATA = 3'd4
	} phase_t;

	phase_t      phase_q, phase_d;
	logic        close_q, close_d;
	logic [3:0]  left_q, left_d;
	logic [63:0] decl_q, decl_d;
	logic [63:0] pos_q, pos_d;
	logic        mask_q, mask_d;
	logic [31:0] key_q, key_d;

	logic [63:0] pos_inc;
	logic [15:0] kept_cur, kept_new;
	logic [6:0]  len_code;
	logic [1:0]  key_sel;
	logic [7:0]  key_byte;

	// min(length, limit); the limit is 16 bits, so the result fits in 16 bits
	function automatic logic [15:0] kept_of(input logic [63:0] len, input logic [15:0] lim);
		logic small_len;
		small_len = (len[63:16] == 48'd0) && (len[15:0] < lim);
		return small_len ? len[15:0] : lim;
	endfunction

	assign len_code = stream_byte[6:0];
	assign pos_inc  = pos_q + 64'd1;
	assign kept_cur = kept_of(decl_q, max_payload_bytes);
	assign kept_new = kept_of(decl_d, max_payload_bytes);
	assign key_sel  = pos_q[1:0];

	// pick the key byte, most significant first
	always_comb begin
		case (key_sel)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// work out next state and the result of this word
	always_comb begin
		phase_d   = phase_q;
		close_d   = close_q;
		left_d    = left_q;
		decl_d    = decl_q;
		pos_d     = pos_q;
		mask_d    = mask_q;
		key_d     = key_q;
		res_valid = 1'b0;
		res       = '0;

		case (phase_q)
			PH_HDR1: begin
				mask_d = stream_byte[7];
				decl_d = 64'd0;
				if (close_q) begin
					res_valid = 1'b1;
					res.kind  = KIND_CLOSE;
				end
				if (len_code == LEN_EXT16 || len_code == LEN_EXT64) begin
					left_d  = (len_code == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
					phase_d = PH_EXT;
				end else begin
					decl_d = {57'd0, len_code};
					key_d  = 32'd0;
					if (stream_byte[7]) begin
						phase_d = PH_MASK;
						left_d  = KEY_BYTES;
					end else begin
						pos_d   = 64'd0;
						phase_d = (len_code == 7'd0) ? PH_HDR0 : PH_DATA;
						if (!close_q && kept_new == 16'd0) begin
							res_valid = 1'b1;
							res.kind  = KIND_EMPTY;
						end
					end
				end
			end
			PH_EXT: begin
				decl_d = {decl_q[55:0], stream_byte};
				left_d = left_q - 4'd1;
				if (left_d == 4'd0) begin
					key_d = 32'd0;
					if (mask_q) begin
						phase_d = PH_MASK;
						left_d  = KEY_BYTES;
					end else begin
						pos_d   = 64'd0;
						phase_d = (decl_d == 64'd0) ? PH_HDR0 : PH_DATA;
						if (!close_q && kept_new == 16'd0) begin
							res_valid = 1'b1;
							res.kind  = KIND_EMPTY;
						end
					end
				end
			end
			PH_MASK: begin
				key_d  = {key_q[23:0], stream_byte};
				left_d = left_q - 4'd1;
				if (left_d == 4'd0) begin
					pos_d   = 64'd0;
					phase_d = (decl_q == 64'd0) ? PH_HDR0 : PH_DATA;
					if (!close_q && kept_cur == 16'd0) begin
						res_valid = 1'b1;
						res.kind  = KIND_EMPTY;
					end
				end
			end
			PH_DATA: begin
				if (!close_q && pos_q[63:16] == 48'd0 && pos_q[15:0] < kept_cur) begin
					res_valid = 1'b1;
					res.kind  = KIND_PAYLOAD;
					res.data  = mask_q ? (stream_byte ^ key_byte) : stream_byte;
					if (pos_inc[15:0] == kept_cur && pos_inc[63:16] == 48'd0) begin
						res.last     = 1'b1;
						res.kept_len = kept_cur;
					end
				end
				pos_d = pos_inc;
				if (pos_inc >= decl_q) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				close_d = (stream_byte[3:0] == OPCODE_CLOSE);
				phase_d = PH_HDR1;
			end
		endcase
	end

	// hold parser state, advance on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			close_q <= 1'b0;
			left_q  <= 4'd0;
			decl_q  <= 64'd0;
			pos_q   <= 64'd0;
			mask_q  <= 1'b0;
			key_q   <= 32'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			close_q <= close_d;
			left_q  <= left_d;
			decl_q  <= decl_d;
			pos_q   <= pos_d;
			mask_q  <= mask_d;
			key_q   <= key_d;
		end
	end

endmodule

>>> design/wsdf_out_buf.sv
module wsdf_out_buf import wsdf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_data
);

	logic    main_valid_q, skid_valid_q;
	result_t main_q, skid_q;
	logic    pop;

	assign pop       = main_valid_q && !out_stall;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;
	assign full      = skid_valid_q;

	// hold valids; refill the output word from skid first, then from the parser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					main_valid_q <= push;
				end
			end else if (push) begin
				if (main_valid_q) begin
					skid_valid_q <= 1'b1;
				end else begin
					main_valid_q <= 1'b1;
				end
			end
		end
	end

	// move payload words
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

>>> design/websocket_frame_deframer_core.sv
// Channel   Direction  Handshake          Word
// input     in         in_valid/in_stall  stream_byte
// output    out        out_valid/out_stall result_kind, payload_byte, last_flag, kept_length
// config    in         cfg_valid/cfg_ready cfg_data (max_payload_bytes)
//
// One stream byte is taken per clock unless stalled; the parser state updates at the
// accepting edge and the result is captured at that edge in the output register, offered
// the next cycle, or held in skid. Reset clears the parser to wait for a frame header and
// sets the limit to 8191. A two-word output buffer (output register plus skid) lets the
// input keep going while a result waits; in_stall rises only once both words are held.
module websocket_frame_deframer_core import wsdf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  stream_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  payload_byte,
	output logic        last_flag,
	output logic [15:0] kept_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic [15:0] max_payload_q;
	logic        accept;
	logic        res_valid;
	result_t     res;
	result_t     out_word;
	logic        buf_full;

	assign cfg_ready = 1'b1;
	assign in_stall  = buf_full;
	assign accept    = in_valid && !buf_full;

	// hold the payload limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_payload_q <= cfg_data;
		end
	end

	wsdf_parser u_parser (
		.clk               (clk),
		.arst_n            (arst_n),
		.accept            (accept),
		.stream_byte       (stream_byte),
		.max_payload_bytes (max_payload_q),
		.res_valid         (res_valid),
		.res               (res)
	);

	wsdf_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_valid),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_word)
	);

	assign result_kind  = out_word.kind;
	assign payload_byte = out_word.data;
	assign last_flag    = out_word.last;
	assign kept_length  = out_word.kept_len;

endmodule

>>> tb/tb_websocket_frame_deframer_core.sv
`timescale 1ns / 100ps

module tb_websocket_frame_deframer_core;
	import wsdf_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int REPORT_LIMIT  = 10;

	typedef enum logic [2:0] {
		PH_HEADER0,
		PH_HEADER1,
		PH_EXTLEN,
		PH_KEY,
		PH_BODY
	} parse_phase_t;

	typedef enum int {
		FORM_SHORT,
		FORM_EXT16,
		FORM_EXT64
	} len_form_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  stream_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  result_kind;
	logic [7:0]  payload_byte;
	logic        last_flag;
	logic [15:0] kept_length;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'h0000;

	// parser copy used to predict the results
	parse_phase_t parse_state = PH_HEADER0;
	logic         frame_close = 1'b0;
	logic [3:0]   bytes_left = 4'd0;
	logic [63:0]  frame_len = 64'd0;
	logic [63:0]  body_pos = 64'd0;
	logic         frame_masked = 1'b0;
	logic [31:0]  frame_key = 32'd0;
	logic [15:0]  limit_model = MAX_PAYLOAD_RESET;

	logic [7:0] byte_queue[$];
	result_t    expected_results[$];

	int send_gap = 0;
	int stall_left = 0;
	int in_idle_pct = 0;
	int out_idle_pct = 0;
	int error_count = 0;
	int results_checked = 0;
	int words_queued = 0;
	int frames_sent = 0;
	int limit_writes = 0;
	int cycle_count = 0;

	websocket_frame_deframer_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.stream_byte  (stream_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.payload_byte (payload_byte),
		.last_flag    (last_flag),
		.kept_length  (kept_length),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// bytes of payload that the current frame may emit
	function automatic logic [63:0] kept_count();
		return (frame_len < {48'd0, limit_model}) ? frame_len : {48'd0, limit_model};
	endfunction

	function automatic bit open_body(output result_t r);
		r = '0;
		body_pos = 64'd0;
		parse_state = (frame_len == 64'd0) ? PH_HEADER0 : PH_BODY;
		if (!frame_close && kept_count() == 64'd0) begin
			r.kind = KIND_EMPTY;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit finish_header(output result_t r);
		r = '0;
		frame_key = 32'd0;
		if (frame_masked) begin
			parse_state = PH_KEY;
			bytes_left  = KEY_BYTES;
			return 1'b0;
		end
		return open_body(r);
	endfunction

	// advance the parser copy by one stream word, return 1 when a result is due
	function automatic bit parse_stream_byte(input logic [7:0] b, output result_t r);
		bit          got;
		result_t     extra;
		logic [63:0] kept;
		got = 1'b0;
		r = '0;
		case (parse_state)
			PH_HEADER1: begin
				frame_masked = b[7];
				frame_len = 64'd0;
				if (frame_close) begin
					r.kind = KIND_CLOSE;
					got = 1'b1;
				end
				if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
					bytes_left  = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
					parse_state = PH_EXTLEN;
				end else begin
					frame_len = {57'd0, b[6:0]};
					if (finish_header(extra) && !got) begin
						r = extra;
						got = 1'b1;
					end
				end
			end
			PH_EXTLEN: begin
				frame_len = {frame_len[55:0], b};
				bytes_left = bytes_left - 4'd1;
				if (bytes_left == 4'd0)
					got = finish_header(r);
			end
			PH_KEY: begin
				frame_key = {frame_key[23:0], b};
				bytes_left = bytes_left - 4'd1;
				if (bytes_left == 4'd0)
					got = open_body(r);
			end
			PH_BODY: begin
				kept = kept_count();
				if (!frame_close && body_pos < kept) begin
					r.kind = KIND_PAYLOAD;
					r.data = b ^ (frame_masked ? frame_key[31 - 8 * body_pos[1:0] -: 8] : 8'h00);
					r.last = (body_pos + 64'd1 == kept);
					r.kept_len = r.last ? kept[15:0] : 16'd0;
					got = 1'b1;
				end
				body_pos = body_pos + 64'd1;
				if (body_pos >= frame_len)
					parse_state = PH_HEADER0;
			end
			default: begin
				frame_close = (b[3:0] == OPCODE_CLOSE);
				parse_state = PH_HEADER1;
			end
		endcase
		return got;
	endfunction

	// mostly no gap, sometimes a short one, rarely a long one
	function automatic int pick_gap(input int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(40, 10);
		return $urandom_range(3, 1);
	endfunction

	function automatic void queue_byte(input logic [7:0] b);
		byte_queue.push_back(b);
		words_queued++;
	endfunction

	task automatic push_frame(input logic [7:0] head0, input bit masked, input len_form_t form,
			input logic [63:0] len, input int body_bytes);
		logic [6:0]  code;
		logic [31:0] mask;
		mask = $urandom;
		case (form)
			FORM_EXT16: code = LEN_EXT16;
			FORM_EXT64: code = LEN_EXT64;
			default:    code = len[6:0];
		endcase
		queue_byte(head0);
		queue_byte({masked, code});
		if (form == FORM_EXT16)
			for (int i = 1; i >= 0; i--)
				queue_byte(len[8 * i +: 8]);
		if (form == FORM_EXT64)
			for (int i = 7; i >= 0; i--)
				queue_byte(len[8 * i +: 8]);
		if (masked)
			for (int i = 3; i >= 0; i--)
				queue_byte(mask[8 * i +: 8]);
		repeat (body_bytes)
			queue_byte(8'($urandom));
		frames_sent++;
	endtask

	// random frame: mostly well formed, now and then cut short
	task automatic push_random_frame();
		logic [7:0] head0;
		int         len;
		int         body;
		len_form_t  form;
		head0 = 8'($urandom);
		if ($urandom_range(99) < 15)
			head0[3:0] = OPCODE_CLOSE;
		len = ($urandom_range(9) == 0) ? $urandom_range(150, 0) : $urandom_range(12, 0);
		if (len > 125)
			form = $urandom_range(1) ? FORM_EXT16 : FORM_EXT64;
		else
			case ($urandom_range(5))
				4:       form = FORM_EXT16;
				5:       form = FORM_EXT64;
				default: form = FORM_SHORT;
			endcase
		body = ($urandom_range(19) == 0) ? $urandom_range(len, 0) : len;
		push_frame(head0, 1'($urandom_range(1)), form, 64'(len), body);
	endtask

	// hold until every queued word is taken and every expected result is in
	task automatic wait_quiet();
		@(negedge clk);
		while (byte_queue.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		limit_model = value;
		limit_writes++;
		cfg_valid <= 1'b0;
	endtask

	// send stream words, predict each accepted word
	always @(posedge clk or negedge arst_n) begin : byte_driver
		result_t want;
		if (!arst_n) begin
			in_valid    <= 1'b0;
			stream_byte <= 8'h00;
			send_gap    <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				if (parse_stream_byte(stream_byte, want))
					expected_results.push_back(want);
			end
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (byte_queue.size() != 0) begin
					in_valid    <= 1'b1;
					stream_byte <= byte_queue.pop_front();
					send_gap    <= pick_gap(in_idle_pct);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// check each result word against the oldest expectation, stall at random
	always @(posedge clk or negedge arst_n) begin : result_monitor
		result_t want;
		int      gap;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("unexpected result: kind %0d byte %h last %0b kept %0d",
							result_kind, payload_byte, last_flag, kept_length);
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (result_kind !== want.kind || payload_byte !== want.data ||
							last_flag !== want.last || kept_length !== want.kept_len) begin
						error_count++;
						if (error_count <= REPORT_LIMIT)
							$display({"result %0d: expected kind %0d byte %h last %0b kept %0d,",
								" got kind %0d byte %h last %0b kept %0d"}, results_checked,
								want.kind, want.data, want.last, want.kept_len,
								result_kind, payload_byte, last_flag, kept_length);
					end
				end
			end
			if (stall_left != 0) begin
				out_stall  <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				gap = pick_gap(out_idle_pct);
				out_stall  <= (gap != 0);
				stall_left <= (gap != 0) ? gap - 1 : 0;
			end
		end
	end

	// abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycle_count, expected_results.size());
			$display("websocket_frame_deframer_core test failed");
			$finish;
		end
	end

	initial begin : stimulus
		logic [15:0] lim;
		int          target;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset limit: plain, masked, empty, close and long-length frames
		in_idle_pct  = 20;
		out_idle_pct = 20;
		queue_byte(8'h82);
		queue_byte(8'h03);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'h5A);
		frames_sent++;
		push_frame(8'h01, 1'b1, FORM_SHORT, 64'd5, 5);
		push_frame(8'h89, 1'b0, FORM_SHORT, 64'd0, 0);
		push_frame(8'h88, 1'b1, FORM_EXT16, 64'd2, 2);
		push_frame(8'h02, 1'b1, FORM_EXT64, 64'd3, 3);
		wait_quiet();

		// zero limit: every frame is empty, close still reported
		write_limit(16'd0);
		push_frame(8'h82, 1'b0, FORM_SHORT, 64'd3, 3);
		push_frame(8'h08, 1'b0, FORM_SHORT, 64'd0, 0);
		wait_quiet();

		// truncation: last flag on the second byte, rest dropped
		write_limit(16'd2);
		push_frame(8'h82, 1'b1, FORM_SHORT, 64'd5, 5);
		wait_quiet();

		// lower the limit below the emitted count mid-frame
		write_limit(16'd4);
		push_frame(8'h82, 1'b1, FORM_SHORT, 64'd6, 2);
		wait_quiet();
		write_limit(16'd1);
		repeat (4) queue_byte(8'($urandom));
		wait_quiet();

		// raise the limit mid-frame
		write_limit(16'd3);
		push_frame(8'h81, 1'b1, FORM_SHORT, 64'd6, 1);
		wait_quiet();
		write_limit(16'd5);
		repeat (5) queue_byte(8'($urandom));
		wait_quiet();

		// random frames under a sweep of limits and idle patterns
		for (int phase_idx = 0; phase_idx < 12; phase_idx++) begin
			case (phase_idx % 6)
				0:       lim = 16'd0;
				1:       lim = 16'hFFFF;
				2:       lim = 16'($urandom_range(4, 1));
				3:       lim = 16'($urandom_range(16, 5));
				4:       lim = 16'($urandom);
				default: lim = MAX_PAYLOAD_RESET;
			endcase
			in_idle_pct  = (phase_idx % 4 == 0) ? 0 : $urandom_range(50, 10);
			out_idle_pct = (phase_idx % 4 == 1) ? 0 : $urandom_range(50, 10);
			write_limit(lim);
			target = words_queued + 160;
			while (words_queued < target) begin
				if ($urandom_range(9) == 0)
					repeat ($urandom_range(5, 1)) queue_byte(8'($urandom));
				else
					push_random_frame();
				if ($urandom_range(29) == 0)
					wait_quiet();
			end
			wait_quiet();
		end

		// 64-bit length with the top bit set: the frame never ends
		in_idle_pct  = 20;
		out_idle_pct = 20;
		write_limit(16'd10);
		push_frame(8'h82, 1'b1, FORM_EXT64, 64'h8000_0000_0000_0005, 24);
		wait_quiet();

		error_count += expected_results.size();
		$display("covered %0d frames in %0d stream words under %0d limit writes,",
			frames_sent, words_queued, limit_writes);
		$display("checked %0d results, %0d errors", results_checked, error_count);
		if (error_count == 0)
			$display("websocket_frame_deframer_core test passed");
		else
			$display("websocket_frame_deframer_core test failed");
		$finish;
	end

endmodule
